>>> hw/rtl/quorum_transaction_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quorum transaction tracker
// Shared property forms. Each expects signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef QUORUM_TRANSACTION_TRACKER_ASSERT_SVH
`define QUORUM_TRANSACTION_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/qtt_pkg.sv
// ----------------------------------------------------------------------------
// qtt_pkg
// Types, codes and constants shared by the quorum transaction tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package qtt_pkg;

  localparam int CMD_BITS     = 2;
  localparam int ID_BITS      = 32;
  localparam int KIND_BITS    = 2;
  localparam int VALUE_BITS   = 32;
  localparam int STATUS_BITS  = 3;
  localparam int COUNT_BITS   = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int TMO_BITS     = 16;

  // Command codes.
  localparam logic [CMD_BITS-1:0] CMD_OPEN  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REPLY = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_NONE  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OPENED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_PENDING = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_SUCCESS = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FAILED  = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 3'd5;

  localparam logic [KIND_BITS-1:0] KIND_READ = 2'd1;
  localparam logic [ID_BITS-1:0] RESERVED_ID = 32'hFFFF_FFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUORUM  = 2'd1;
  localparam logic [TMO_BITS-1:0]   TIMEOUT_RESET = 16'd40;
  localparam logic [COUNT_BITS-1:0] QUORUM_RESET  = 2'd2;

  // Queue between the front and the back.
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;
  localparam int Q_CNT_BITS = 2;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [ID_BITS-1:0]    id;
    logic [KIND_BITS-1:0]  kind;
    logic                  ok;
    logic [VALUE_BITS-1:0] value;
    logic                  reserved;
  } qtt_req_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     done_id;
    logic [KIND_BITS-1:0]   done_kind;
    logic [VALUE_BITS-1:0]  read_value;
    logic                   timed_out;
    logic                   last;
  } qtt_res_t;

  // Queue occupancy seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } qtt_qstat_t;

  // Saturating increment of a reply counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qtt_in_if.sv
// ----------------------------------------------------------------------------
// qtt_in_if
// Request channel into the tracker: valid, ready and the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtt_in_if
  import qtt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [ID_BITS-1:0]    trans_id;
  logic [KIND_BITS-1:0]  op_kind;
  logic                  reply_ok;
  logic [VALUE_BITS-1:0] value_word;

  modport source (output valid, command, trans_id, op_kind, reply_ok, value_word,
                  input ready);
  modport sink   (input valid, command, trans_id, op_kind, reply_ok, value_word,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qtt_out_if.sv
// ----------------------------------------------------------------------------
// qtt_out_if
// Result channel out of the tracker: valid, ready and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtt_out_if
  import qtt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]     done_id;
  logic [KIND_BITS-1:0]   done_kind;
  logic [VALUE_BITS-1:0]  read_value;
  logic                   timed_out;
  logic                   last;

  modport source (output valid, status, done_id, done_kind, read_value, timed_out, last,
                  input ready);
  modport sink   (input valid, status, done_id, done_kind, read_value, timed_out, last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qtt_cfg_if.sv
// ----------------------------------------------------------------------------
// qtt_cfg_if
// Configuration write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtt_cfg_if
  import qtt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/qtt_ram.sv
// ----------------------------------------------------------------------------
// qtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

`default_nettype wire

>>> hw/rtl/qtt_front.sv
// ----------------------------------------------------------------------------
// qtt_front
// Accepts requests, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_front
  import qtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  qtt_in_if.sink     in_chan,
  input  qtt_qstat_t q_stat,
  output logic       q_push,
  output qtt_req_t   q_data
);
  logic     stg_v_r, stg_v_nxt;
  qtt_req_t stg_r;
  logic     take;

  assign q_push        = stg_v_r && !q_stat.full;
  assign in_chan.ready = !stg_v_r || q_push;
  assign take          = in_chan.valid && in_chan.ready;
  assign q_data        = stg_r;

  // The unused command is accepted and dropped here; it never reaches the table.
  always_comb begin
    stg_v_nxt = stg_v_r;
    if (take) begin
      stg_v_nxt = (in_chan.command != CMD_NONE);
    end else if (q_push) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_r.cmd      <= in_chan.command;
      stg_r.id       <= in_chan.trans_id;
      stg_r.kind     <= in_chan.op_kind;
      stg_r.ok       <= in_chan.reply_ok;
      stg_r.value    <= in_chan.value_word;
      stg_r.reserved <= (in_chan.trans_id == RESERVED_ID);
    end
  end
endmodule

`default_nettype wire

>>> hw/rtl/qtt_queue.sv
// ----------------------------------------------------------------------------
// qtt_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_queue
  import qtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qtt_req_t   push_data,
  input  logic       pop,
  output qtt_req_t   pop_data,
  output qtt_qstat_t stat
);
  qtt_req_t                slot_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end
endmodule

`default_nettype wire

>>> hw/rtl/qtt_back.sv
// ----------------------------------------------------------------------------
// qtt_back
// Transaction table: id match, entry updates, expiry sweep and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quorum_transaction_tracker_assert.svh"

module qtt_back
  import qtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  qtt_cfg_if.sink    cfg_chan,
  input  qtt_req_t   q_data,
  input  qtt_qstat_t q_stat,
  output logic       q_pop,
  qtt_out_if.source  out_chan
);
  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int CMP_BITS = (TIME_BITS > TMO_BITS) ? TIME_BITS : TMO_BITS;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REPLY = 3'd1;
  localparam logic [2:0] S_TREAD = 3'd2;
  localparam logic [2:0] S_TCHK  = 3'd3;
  localparam logic [2:0] S_TEND  = 3'd4;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [KIND_BITS-1:0]  kind;
    logic [COUNT_BITS-1:0] succ;
    logic [COUNT_BITS-1:0] fail;
    logic [TIME_BITS-1:0]  opened;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  logic [2:0]             state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [ID_BITS-1:0]     cam_id_r [TABLE_DEPTH];
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic [TMO_BITS-1:0]    tmo_r;
  logic [COUNT_BITS-1:0]  quo_r;
  qtt_req_t               cur_r, cur_nxt;
  logic [IDX_BITS-1:0]    idx_r, idx_nxt;
  logic                   hold_v_r, hold_v_nxt;
  qtt_res_t               hold_r, hold_nxt;
  logic                   out_v_r, out_v_nxt;
  qtt_res_t               out_r, load_res;
  logic                   out_load;

  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [IDX_BITS-1:0]    hit_idx, free_idx;
  logic                   any_hit, table_full, ofree, cam_we;
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr, ram_raddr;
  entry_t                 wr_entry, rd_entry;
  logic [TIME_BITS-1:0]   age;
  logic                   expired;
  logic [COUNT_BITS-1:0]  succ2, fail2;
  logic [VALUE_BITS-1:0]  val2;
  logic                   tick_take, full_emit, hold_in_tick;

  qtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // Parallel id match against the valid entries.
  always_comb begin
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      hit_vec[s] = valid_r[s] && (cam_id_r[s] == q_data.id);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
      if (hit_vec[s]) begin
        hit_idx = IDX_BITS'(s);
      end
      if (!valid_r[s]) begin
        free_idx = IDX_BITS'(s);
      end
    end
  end

  assign any_hit    = |hit_vec;
  assign table_full = &valid_r;
  assign ofree      = !out_v_r || out_chan.ready;
  assign age        = now_r - rd_entry.opened;
  assign expired    = CMP_BITS'(age) > CMP_BITS'(tmo_r);

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    now_nxt    = now_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    q_pop      = 1'b0;
    cam_we     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_raddr  = idx_r;
    wr_entry   = rd_entry;
    out_load   = 1'b0;
    load_res   = '0;
    succ2      = rd_entry.succ;
    fail2      = rd_entry.fail;
    val2       = rd_entry.value;
    case (state_r)
      S_IDLE: begin
        ram_raddr = hit_idx;
        if (!q_stat.empty && ofree) begin
          q_pop = 1'b1;
          case (q_data.cmd)
            CMD_OPEN: begin
              out_load           = 1'b1;
              load_res.status    = (!any_hit && table_full) ? ST_FULL : ST_OPENED;
              load_res.done_id   = q_data.id;
              load_res.done_kind = q_data.kind;
              load_res.last      = 1'b1;
              if (!any_hit && !table_full) begin
                valid_nxt[free_idx] = 1'b1;
                cam_we          = 1'b1;
                ram_we          = 1'b1;
                ram_waddr       = free_idx;
                wr_entry.id     = q_data.id;
                wr_entry.kind   = q_data.kind;
                wr_entry.succ   = '0;
                wr_entry.fail   = '0;
                wr_entry.opened = now_r;
                wr_entry.value  = '0;
              end
            end
            CMD_REPLY: begin
              if (q_data.reserved || !any_hit) begin
                out_load         = 1'b1;
                load_res.status  = ST_UNKNOWN;
                load_res.done_id = q_data.id;
                load_res.last    = 1'b1;
              end else begin
                cur_nxt   = q_data;
                idx_nxt   = hit_idx;
                state_nxt = S_REPLY;
              end
            end
            CMD_TICK: begin
              now_nxt   = now_r + 1'b1;
              idx_nxt   = '0;
              state_nxt = S_TREAD;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPLY: begin
        if (ofree) begin
          if (cur_r.ok) begin
            succ2 = sat_inc(rd_entry.succ);
          end else begin
            fail2 = sat_inc(rd_entry.fail);
          end
          if (rd_entry.kind == KIND_READ) begin
            val2 = cur_r.value;
          end
          wr_entry.succ       = succ2;
          wr_entry.fail       = fail2;
          wr_entry.value      = val2;
          ram_we              = 1'b1;
          out_load            = 1'b1;
          load_res.done_id    = rd_entry.id;
          load_res.done_kind  = rd_entry.kind;
          load_res.read_value = (rd_entry.kind == KIND_READ) ? val2 : '0;
          load_res.last       = 1'b1;
          // Success is checked first so that it wins over a simultaneous expiry.
          if (succ2 >= quo_r) begin
            load_res.status  = ST_SUCCESS;
            valid_nxt[idx_r] = 1'b0;
          end else if (fail2 >= quo_r) begin
            load_res.status  = ST_FAILED;
            valid_nxt[idx_r] = 1'b0;
          end else if (expired) begin
            load_res.status    = ST_FAILED;
            load_res.timed_out = 1'b1;
            valid_nxt[idx_r]   = 1'b0;
          end else begin
            load_res.status = ST_PENDING;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TREAD: begin
        if (valid_r[idx_r]) begin
          state_nxt = S_TCHK;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_TEND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TCHK: begin
        // An expired entry is parked in the hold register; the one parked
        // before it goes out now, since it is known not to be the last.
        if (!expired || !hold_v_r || ofree) begin
          if (expired) begin
            if (hold_v_r) begin
              out_load = 1'b1;
              load_res = hold_r;
            end
            hold_v_nxt          = 1'b1;
            hold_nxt            = '0;
            hold_nxt.status     = ST_FAILED;
            hold_nxt.done_id    = rd_entry.id;
            hold_nxt.done_kind  = rd_entry.kind;
            hold_nxt.read_value = (rd_entry.kind == KIND_READ) ? rd_entry.value : '0;
            hold_nxt.timed_out  = 1'b1;
            valid_nxt[idx_r]    = 1'b0;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_TEND;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TREAD;
          end
        end
      end
      S_TEND: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (ofree) begin
          out_load      = 1'b1;
          load_res      = hold_r;
          load_res.last = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      now_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      tmo_r    <= TIMEOUT_RESET;
      quo_r    <= QUORUM_RESET;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      now_r    <= now_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.reg_index)
          CFG_TIMEOUT: tmo_r <= cfg_chan.wdata[TMO_BITS-1:0];
          CFG_QUORUM:  quo_r <= cfg_chan.wdata[COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
    if (cam_we) begin
      cam_id_r[free_idx] <= q_data.id;
    end
    if (out_load) begin
      out_r <= load_res;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.status     = out_r.status;
  assign out_chan.done_id    = out_r.done_id;
  assign out_chan.done_kind  = out_r.done_kind;
  assign out_chan.read_value = out_r.read_value;
  assign out_chan.timed_out  = out_r.timed_out;
  assign out_chan.last       = out_r.last;

  assign tick_take    = (state_r == S_IDLE) && q_pop && (q_data.cmd == CMD_TICK);
  assign full_emit    = out_load && (load_res.status == ST_FULL);
  assign hold_in_tick = (state_r == S_TREAD) || (state_r == S_TCHK) || (state_r == S_TEND);

  `QTT_ASSERT_SAME(a_full_needs_full_table, full_emit, table_full, "table full with free slot")
  `QTT_ASSERT_SAME(a_hold_only_in_sweep, hold_v_r, hold_in_tick, "held result outside sweep")
  `QTT_ASSERT_NEXT(a_tick_advances_time, tick_take, now_r == $past(now_nxt), "tick lost")

endmodule

`default_nettype wire

>>> hw/rtl/quorum_transaction_tracker.sv
// ----------------------------------------------------------------------------
// quorum_transaction_tracker
// Table of outstanding replicated transactions with quorum and expiry.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   in_chan   sink       valid/ready    command, trans_id, op_kind, reply_ok,
//                                       value_word
//   out_chan  source     valid/ready    status, done_id, done_kind, read_value,
//                                       timed_out, last
//   cfg_chan  sink       valid/ready    reg_index, wdata (ready is always high)
//
// An open request is settled in the table's idle state once it reaches the
// head of the queue; a reply goes through the id match, then the registered
// entry RAM read. A tick is popped, then sweeps the entry RAM one slot at a
// time: a free slot is passed over in the read state, a used one is read and
// then checked for expiry, and a final state sends the last held result.
// Reset (rst_n low, synchronous) clears all valid bits, time and queues and
// loads the default timeout and quorum; entry RAM contents need no clearing.
// A stalled result holds in the output register while the front keeps
// accepting requests into the queue until it fills.
//
`default_nettype none

module quorum_transaction_tracker
  import qtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qtt_in_if.sink    in_chan,
  qtt_out_if.source out_chan,
  qtt_cfg_if.sink   cfg_chan
);
  // Requests flow front -> queue -> back. The front only classifies; all
  // table state lives in the back.
  logic       push, pop;
  qtt_req_t   front_req, head_req;
  qtt_qstat_t q_stat;

  qtt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .q_push  (push),
    .q_data  (front_req)
  );

  qtt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_req),
    .pop       (pop),
    .pop_data  (head_req),
    .stat      (q_stat)
  );

  // The back pops one request at a time and finishes it, including any
  // expiry sweep, before it looks at the next.
  qtt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .q_data   (head_req),
    .q_stat   (q_stat),
    .q_pop    (pop),
    .out_chan (out_chan)
  );
endmodule

`default_nettype wire
